// File: sv/rrcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcc_pkg
// Shared types, widths and constants of the RGB reflectance color classifier.
// ----------------------------------------------------------------------------
package rrcc_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int GREEN_BITS     = SAMPLE_BITS + 1;
   localparam int CFG_BITS       = 12;
   localparam int CSR_INDEX_BITS = 1;
   localparam int SUM_BITS       = SAMPLE_BITS + 2;
   localparam int QUO_BITS       = 10;
   localparam int NUM_BITS       = GREEN_BITS + QUO_BITS;
   localparam int CNT_BITS       = $clog2(QUO_BITS);
   localparam int CMP_BITS       = ((GREEN_BITS > CFG_BITS) ? GREEN_BITS : CFG_BITS) + 1;
   localparam int TIMES7_BITS    = SAMPLE_BITS + 3;

   // floor(y / 10) = (y * RECIP) >> RECIP_SHIFT, exact for y below 2**22
   localparam int RECIP_SHIFT    = 23;
   localparam int RECIP_BITS     = 20;
   localparam int PROD_BITS      = TIMES7_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] BLUE_RECIP = RECIP_BITS'(838861);

   localparam logic [QUO_BITS-1:0] SHARE_SCALE = QUO_BITS'(1000);

   localparam logic [CFG_BITS-1:0] DARK_THRESHOLD_RESET    = CFG_BITS'(80);
   localparam logic [CFG_BITS-1:0] GREEN_BLUE_MARGIN_RESET = CFG_BITS'(80);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DARK_THRESHOLD    = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GREEN_BLUE_MARGIN = 1'd1;

   typedef enum logic [1:0] {
      CLASS_NONE  = 2'd0,
      CLASS_GREEN = 2'd1,
      CLASS_RED   = 2'd2,
      CLASS_BLUE  = 2'd3
   } color_class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_STORE,
      ST_PREP,
      ST_DIVIDE,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic capture;
      logic scale;
      logic store;
      logic prep;
      logic div_step;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   function automatic logic [SAMPLE_BITS-1:0] corrected(
      input logic [SAMPLE_BITS-1:0] sample,
      input logic [SAMPLE_BITS-1:0] dark
   );
      return (sample > dark) ? (sample - dark) : '0;
   endfunction

endpackage

// File: sv/rrcc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcc_ctrl
// Sequencer: capture, level scaling, store, share setup, divide, result load.
// ----------------------------------------------------------------------------
module rrcc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rrcc_pkg::dp_status_type status,
   output rrcc_pkg::dp_cmd_type   cmd
);

   rrcc_pkg::state_type               state_ff, state_in;
   logic [rrcc_pkg::CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                              div_last;

   assign div_last = (cnt_ff == rrcc_pkg::CNT_BITS'(rrcc_pkg::QUO_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrcc_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrcc_pkg::ST_IDLE: begin
            if (req_valid) state_in = rrcc_pkg::ST_LEVEL;
         end
         rrcc_pkg::ST_LEVEL:  state_in = rrcc_pkg::ST_STORE;
         rrcc_pkg::ST_STORE:  state_in = rrcc_pkg::ST_PREP;
         rrcc_pkg::ST_PREP:   state_in = rrcc_pkg::ST_DIVIDE;
         rrcc_pkg::ST_DIVIDE: begin
            if (div_last) state_in = rrcc_pkg::ST_LOAD;
         end
         rrcc_pkg::ST_LOAD: begin
            if (status.out_free) state_in = rrcc_pkg::ST_IDLE;
         end
         default: state_in = rrcc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      cnt_in    = cnt_ff;
      case (state_ff)
         rrcc_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         rrcc_pkg::ST_LEVEL: cmd.scale = 1'b1;
         rrcc_pkg::ST_STORE: cmd.store = 1'b1;
         rrcc_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
         end
         rrcc_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
         end
         rrcc_pkg::ST_LOAD: cmd.load = status.out_free;
         default: ;
      endcase
   end

endmodule

// File: sv/rrcc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcc_datapath
// Sample registers, level scaling, stored levels, three-lane restoring
// divider for the shares, classification, config and result registers.
// ----------------------------------------------------------------------------
module rrcc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rrcc_pkg::dp_cmd_type                cmd,
   output rrcc_pkg::dp_status_type             status,
   input  logic [rrcc_pkg::SAMPLE_BITS-1:0]    req_dark_sample,
   input  logic [rrcc_pkg::SAMPLE_BITS-1:0]    req_red_sample,
   input  logic [rrcc_pkg::SAMPLE_BITS-1:0]    req_green_sample,
   input  logic [rrcc_pkg::SAMPLE_BITS-1:0]    req_blue_sample,
   input  logic                                req_hold,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rrcc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rrcc_pkg::CFG_BITS-1:0]       csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rrcc_pkg::SAMPLE_BITS-1:0]    rsp_red_level,
   output logic [rrcc_pkg::GREEN_BITS-1:0]     rsp_green_level,
   output logic [rrcc_pkg::SAMPLE_BITS-1:0]    rsp_blue_level,
   output logic [rrcc_pkg::QUO_BITS-1:0]       rsp_red_share,
   output logic [rrcc_pkg::QUO_BITS-1:0]       rsp_green_share,
   output logic [rrcc_pkg::QUO_BITS-1:0]       rsp_blue_share,
   output logic [1:0]                          rsp_color_class
);

   localparam int S  = rrcc_pkg::SAMPLE_BITS;
   localparam int G  = rrcc_pkg::GREEN_BITS;
   localparam int N  = rrcc_pkg::NUM_BITS;
   localparam int Q  = rrcc_pkg::QUO_BITS;
   localparam int C  = rrcc_pkg::CMP_BITS;
   localparam int T7 = rrcc_pkg::TIMES7_BITS;

   // config
   logic [rrcc_pkg::CFG_BITS-1:0] thr_ff, margin_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= rrcc_pkg::DARK_THRESHOLD_RESET;
         margin_ff <= rrcc_pkg::GREEN_BLUE_MARGIN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            rrcc_pkg::CSR_DARK_THRESHOLD:    thr_ff    <= csr_wdata;
            rrcc_pkg::CSR_GREEN_BLUE_MARGIN: margin_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured beat
   logic [S-1:0] dark_ff, red_ff, green_ff, blue_ff;
   logic         hold_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dark_ff  <= req_dark_sample;
         red_ff   <= req_red_sample;
         green_ff <= req_green_sample;
         blue_ff  <= req_blue_sample;
         hold_ff  <= req_hold;
      end
   end

   // level scaling
   logic [S-1:0]                   cr, cg, cb;
   logic [T7-1:0]                  g5, b7;
   logic [S-1:0]                   lvl_red_ff, lvl_red_in;
   logic [G-1:0]                   lvl_green_ff, lvl_green_in;
   logic [rrcc_pkg::PROD_BITS-1:0] blue_prod_ff, blue_prod_in;

   always_comb begin
      cr           = rrcc_pkg::corrected(red_ff, dark_ff);
      cg           = rrcc_pkg::corrected(green_ff, dark_ff);
      cb           = rrcc_pkg::corrected(blue_ff, dark_ff);
      g5           = (T7'(cg) << 2) + T7'(cg);
      b7           = (T7'(cb) << 3) - T7'(cb);
      lvl_red_in   = cr;
      lvl_green_in = g5[G+1:2];
      blue_prod_in = rrcc_pkg::PROD_BITS'(b7) * rrcc_pkg::PROD_BITS'(rrcc_pkg::BLUE_RECIP);
   end

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         lvl_red_ff   <= lvl_red_in;
         lvl_green_ff <= lvl_green_in;
         blue_prod_ff <= blue_prod_in;
      end
   end

   // stored levels
   logic [S-1:0] st_red_ff, st_blue_ff;
   logic [G-1:0] st_green_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_red_ff   <= '0;
         st_green_ff <= '0;
         st_blue_ff  <= '0;
      end else if (cmd.store && !hold_ff) begin
         st_red_ff   <= lvl_red_ff;
         st_green_ff <= lvl_green_ff;
         st_blue_ff  <= blue_prod_ff[rrcc_pkg::RECIP_SHIFT +: S];
      end
   end

   // share setup and classification
   logic [rrcc_pkg::SUM_BITS-1:0] sum_w, divisor;
   logic [G-1:0]                  lvl [3];
   logic [N-1:0]                  num_in [3];
   logic [N-1:0]                  rem_ff [3];
   logic [N-1:0]                  rem_in [3];
   logic [Q-1:0]                  quo_ff [3];
   logic [Q-1:0]                  quo_in [3];
   logic [N-1:0]                  dsh_ff, dsh_in;
   logic [C-1:0]                  cr_x, cg_x, cb_x, thr_x, gm_x;
   rrcc_pkg::color_class_type     class_ff, class_in;

   always_comb begin
      lvl[0]  = G'(st_red_ff);
      lvl[1]  = st_green_ff;
      lvl[2]  = G'(st_blue_ff);
      sum_w   = rrcc_pkg::SUM_BITS'(st_red_ff) + rrcc_pkg::SUM_BITS'(st_green_ff)
              + rrcc_pkg::SUM_BITS'(st_blue_ff);
      divisor = (sum_w == '0) ? rrcc_pkg::SUM_BITS'(1) : sum_w;
      for (int i = 0; i < 3; i++) begin
         num_in[i] = N'(lvl[i]) * N'(rrcc_pkg::SHARE_SCALE) + N'(divisor >> 1);
      end
   end

   always_comb begin
      cr_x  = C'(st_red_ff);
      cg_x  = C'(st_green_ff);
      cb_x  = C'(st_blue_ff);
      thr_x = C'(thr_ff);
      gm_x  = cg_x + C'(margin_ff);
      if (cr_x < thr_x && cg_x < thr_x && cb_x < thr_x) begin
         class_in = rrcc_pkg::CLASS_NONE;
      end else if (cg_x >= cr_x && gm_x >= cb_x) begin
         class_in = rrcc_pkg::CLASS_GREEN;
      end else if (cr_x >= cg_x && cr_x >= cb_x) begin
         class_in = rrcc_pkg::CLASS_RED;
      end else begin
         class_in = rrcc_pkg::CLASS_BLUE;
      end
   end

   // divider, one quotient bit per step in each lane
   always_comb begin
      dsh_in = dsh_ff;
      for (int i = 0; i < 3; i++) begin
         rem_in[i] = rem_ff[i];
         quo_in[i] = quo_ff[i];
      end
      if (cmd.prep) begin
         dsh_in = N'(divisor) << (Q - 1);
         for (int i = 0; i < 3; i++) begin
            rem_in[i] = num_in[i];
            quo_in[i] = '0;
         end
      end else if (cmd.div_step) begin
         dsh_in = dsh_ff >> 1;
         for (int i = 0; i < 3; i++) begin
            if (rem_ff[i] >= dsh_ff) begin
               rem_in[i] = rem_ff[i] - dsh_ff;
               quo_in[i] = {quo_ff[i][Q-2:0], 1'b1};
            end else begin
               quo_in[i] = {quo_ff[i][Q-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      dsh_ff <= dsh_in;
      for (int i = 0; i < 3; i++) begin
         rem_ff[i] <= rem_in[i];
         quo_ff[i] <= quo_in[i];
      end
      if (cmd.prep) class_ff <= class_in;
   end

   // result register
   logic                      rsp_valid_ff;
   logic [S-1:0]              out_red_ff, out_blue_ff;
   logic [G-1:0]              out_green_ff;
   logic [Q-1:0]              out_rs_ff, out_gs_ff, out_bs_ff;
   rrcc_pkg::color_class_type out_class_ff;

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_red_ff   <= st_red_ff;
         out_green_ff <= st_green_ff;
         out_blue_ff  <= st_blue_ff;
         out_rs_ff    <= quo_ff[0];
         out_gs_ff    <= quo_ff[1];
         out_bs_ff    <= quo_ff[2];
         out_class_ff <= class_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_level   = out_red_ff;
   assign rsp_green_level = out_green_ff;
   assign rsp_blue_level  = out_blue_ff;
   assign rsp_red_share   = out_rs_ff;
   assign rsp_green_share = out_gs_ff;
   assign rsp_blue_share  = out_bs_ff;
   assign rsp_color_class = out_class_ff;

endmodule

// File: sv/rgb_reflectance_color_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_reflectance_color_classifier_unit
// Dark-corrected RGB levels, their shares of the sum and a color class.
// ----------------------------------------------------------------------------
// One measurement beat at a time: a beat is taken when the unit is idle, its
// result is registered after the level scaling, store, share setup, divide
// and load states, and the next beat can be taken once that load is done.
// The pace is set by the 10-step restoring divider that forms the three
// shares in parallel lanes. A finished result waits in its own register, so a
// stalled result side holds the unit only once the next result is ready.
// The configuration port never stalls.
module rgb_reflectance_color_classifier_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rrcc_pkg::SAMPLE_BITS-1:0]    req_dark_sample,
   input  logic [rrcc_pkg::SAMPLE_BITS-1:0]    req_red_sample,
   input  logic [rrcc_pkg::SAMPLE_BITS-1:0]    req_green_sample,
   input  logic [rrcc_pkg::SAMPLE_BITS-1:0]    req_blue_sample,
   input  logic                                req_hold,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rrcc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rrcc_pkg::CFG_BITS-1:0]       csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rrcc_pkg::SAMPLE_BITS-1:0]    rsp_red_level,
   output logic [rrcc_pkg::GREEN_BITS-1:0]     rsp_green_level,
   output logic [rrcc_pkg::SAMPLE_BITS-1:0]    rsp_blue_level,
   output logic [rrcc_pkg::QUO_BITS-1:0]       rsp_red_share,
   output logic [rrcc_pkg::QUO_BITS-1:0]       rsp_green_share,
   output logic [rrcc_pkg::QUO_BITS-1:0]       rsp_blue_share,
   output logic [1:0]                          rsp_color_class
);

   rrcc_pkg::dp_cmd_type    cmd;
   rrcc_pkg::dp_status_type status;

   rrcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rrcc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_dark_sample  (req_dark_sample),
      .req_red_sample   (req_red_sample),
      .req_green_sample (req_green_sample),
      .req_blue_sample  (req_blue_sample),
      .req_hold         (req_hold),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red_level    (rsp_red_level),
      .rsp_green_level  (rsp_green_level),
      .rsp_blue_level   (rsp_blue_level),
      .rsp_red_share    (rsp_red_share),
      .rsp_green_share  (rsp_green_share),
      .rsp_blue_share   (rsp_blue_share),
      .rsp_color_class  (rsp_color_class)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accepted beat");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load))
      else $error("rsp_valid rose without a result load");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.out_free)
      else $error("result loaded over an untaken beat");

   a_share_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red_share <= 10'd1000) && (rsp_green_share <= 10'd1000)
                    && (rsp_blue_share <= 10'd1000))
      else $error("share above 1000");

endmodule

// File: tb/tb_rgb_reflectance_color_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_reflectance_color_classifier_unit
// Self-checking bench for the RGB reflectance color classifier.
// ----------------------------------------------------------------------------
// A queue of measurements feeds a valid/ready driver. When a beat is taken, a
// local model of the unit works out the levels, shares and class that it
// should give. A clocked monitor checks every result beat against the oldest
// of these predictions. Directed corner cases run first. Random measurements
// follow under several register settings, with a range of idle and stall
// mixes on both channels.
// ----------------------------------------------------------------------------
module tb_rgb_reflectance_color_classifier_unit;
   import rrcc_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int PHASE_ITEMS  = 106;
   localparam int MAX_SAMPLE   = (1 << SAMPLE_BITS) - 1;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] dark;
      logic [SAMPLE_BITS-1:0] red;
      logic [SAMPLE_BITS-1:0] green;
      logic [SAMPLE_BITS-1:0] blue;
      logic                   hold;
   } meas_t;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] red_level;
      logic [GREEN_BITS-1:0]  green_level;
      logic [SAMPLE_BITS-1:0] blue_level;
      logic [QUO_BITS-1:0]    red_share;
      logic [QUO_BITS-1:0]    green_share;
      logic [QUO_BITS-1:0]    blue_share;
      color_class_type        color_class;
   } color_result_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [SAMPLE_BITS-1:0]    req_dark_sample = '0;
   logic [SAMPLE_BITS-1:0]    req_red_sample = '0;
   logic [SAMPLE_BITS-1:0]    req_green_sample = '0;
   logic [SAMPLE_BITS-1:0]    req_blue_sample = '0;
   logic                      req_hold = 1'b0;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_DARK_THRESHOLD;
   logic [CFG_BITS-1:0]       csr_wdata = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [SAMPLE_BITS-1:0]    rsp_red_level;
   logic [GREEN_BITS-1:0]     rsp_green_level;
   logic [SAMPLE_BITS-1:0]    rsp_blue_level;
   logic [QUO_BITS-1:0]       rsp_red_share;
   logic [QUO_BITS-1:0]       rsp_green_share;
   logic [QUO_BITS-1:0]       rsp_blue_share;
   logic [1:0]                rsp_color_class;

   // local copy of the unit's registers and held levels
   logic [CFG_BITS-1:0]    thr_cfg = DARK_THRESHOLD_RESET;
   logic [CFG_BITS-1:0]    margin_cfg = GREEN_BLUE_MARGIN_RESET;
   logic [SAMPLE_BITS-1:0] held_red = '0;
   logic [GREEN_BITS-1:0]  held_green = '0;
   logic [SAMPLE_BITS-1:0] held_blue = '0;

   meas_t         pending_meas_q[$];
   color_result_t awaited_colors_q[$];
   meas_t         meas_on_bus;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int fault_count = 0;
   int cycle_count = 0;
   int meas_sent = 0;
   int hold_sent = 0;
   int colors_seen = 0;
   int setting_count = 0;
   int class_hits[4] = '{default: 0};

   rgb_reflectance_color_classifier_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_dark_sample  (req_dark_sample),
      .req_red_sample   (req_red_sample),
      .req_green_sample (req_green_sample),
      .req_blue_sample  (req_blue_sample),
      .req_hold         (req_hold),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red_level    (rsp_red_level),
      .rsp_green_level  (rsp_green_level),
      .rsp_blue_level   (rsp_blue_level),
      .rsp_red_share    (rsp_red_share),
      .rsp_green_share  (rsp_green_share),
      .rsp_blue_share   (rsp_blue_share),
      .rsp_color_class  (rsp_color_class)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic color_result_t predict_color(input meas_t m);
      int unsigned   r;
      int unsigned   g;
      int unsigned   b;
      int unsigned   sum;
      color_result_t res;
      if (!m.hold) begin
         r = (m.red > m.dark) ? m.red - m.dark : 0;
         g = (m.green > m.dark) ? m.green - m.dark : 0;
         b = (m.blue > m.dark) ? m.blue - m.dark : 0;
         held_red = SAMPLE_BITS'(r);
         held_green = GREEN_BITS'((g * 5) / 4);
         held_blue = SAMPLE_BITS'((b * 7) / 10);
      end
      r = held_red;
      g = held_green;
      b = held_blue;
      sum = r + g + b;
      if (sum == 0) begin
         sum = 1;
      end
      res.red_level = held_red;
      res.green_level = held_green;
      res.blue_level = held_blue;
      res.red_share = QUO_BITS'((r * 1000 + sum / 2) / sum);
      res.green_share = QUO_BITS'((g * 1000 + sum / 2) / sum);
      res.blue_share = QUO_BITS'((b * 1000 + sum / 2) / sum);
      if (r < thr_cfg && g < thr_cfg && b < thr_cfg) begin
         res.color_class = CLASS_NONE;
      end else if (g >= r && g + margin_cfg >= b) begin
         res.color_class = CLASS_GREEN;
      end else if (r >= g && r >= b) begin
         res.color_class = CLASS_RED;
      end else begin
         res.color_class = CLASS_BLUE;
      end
      return res;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] near_level(input int v);
      v = v + int'($urandom_range(160)) - 40;
      if (v < 0) begin
         v = 0;
      end
      if (v > MAX_SAMPLE) begin
         v = MAX_SAMPLE;
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] edge_sample();
      case ($urandom_range(2))
         0: return '0;
         1: return SAMPLE_BITS'(MAX_SAMPLE);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic meas_t random_meas();
      meas_t m;
      int    base;
      m.dark = SAMPLE_BITS'($urandom);
      m.red = SAMPLE_BITS'($urandom);
      m.green = SAMPLE_BITS'($urandom);
      m.blue = SAMPLE_BITS'($urandom);
      m.hold = 1'b0;
      case ($urandom_range(9))
         0: m.hold = 1'b1;
         1: ;
         2, 3, 4, 5: m.dark = SAMPLE_BITS'($urandom_range(255));
         6, 7: begin
            // colors close to the dark reading: clamping and threshold edges
            m.red = near_level(m.dark);
            m.green = near_level(m.dark);
            m.blue = near_level(m.dark);
         end
         8: begin
            // levels close to one another: ties and the green/blue margin
            base = $urandom_range(MAX_SAMPLE);
            m.dark = SAMPLE_BITS'($urandom_range(63));
            m.red = near_level(base);
            m.green = near_level(base * 4 / 5);
            m.blue = near_level(base * 10 / 7);
         end
         default: begin
            m.dark = edge_sample();
            m.red = edge_sample();
            m.green = edge_sample();
            m.blue = edge_sample();
         end
      endcase
      return m;
   endfunction

   task automatic add_meas(input logic [SAMPLE_BITS-1:0] dark,
                           input logic [SAMPLE_BITS-1:0] red,
                           input logic [SAMPLE_BITS-1:0] green,
                           input logic [SAMPLE_BITS-1:0] blue,
                           input logic hold);
      meas_t m;
      m.dark = dark;
      m.red = red;
      m.green = green;
      m.blue = blue;
      m.hold = hold;
      pending_meas_q.push_back(m);
   endtask

   // checked between edges so the driver's pop and valid are both settled
   task automatic wait_idle();
      while (pending_meas_q.size() != 0 || req_valid || awaited_colors_q.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   // both registers in back-to-back beats; valid stays high between them
   task automatic apply_setting(input logic [CFG_BITS-1:0] thr,
                                input logic [CFG_BITS-1:0] margin);
      csr_valid <= 1'b1;
      csr_index <= CSR_DARK_THRESHOLD;
      csr_wdata <= thr;
      do @(posedge clock); while (!csr_ready);
      thr_cfg = thr;
      csr_index <= CSR_GREEN_BLUE_MARGIN;
      csr_wdata <= margin;
      do @(posedge clock); while (!csr_ready);
      margin_cfg = margin;
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct,
                                   input logic [CFG_BITS-1:0] thr,
                                   input logic [CFG_BITS-1:0] margin);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      apply_setting(thr, margin);
      repeat (PHASE_ITEMS) pending_meas_q.push_back(random_meas());
      wait_idle();
   endtask

   // measurement driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_colors_q.push_back(predict_color(meas_on_bus));
            meas_sent++;
            if (meas_on_bus.hold) begin
               hold_sent++;
            end
         end
         if (!req_valid || req_ready) begin
            if (pending_meas_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               meas_on_bus = pending_meas_q.pop_front();
               req_valid <= 1'b1;
               req_dark_sample <= meas_on_bus.dark;
               req_red_sample <= meas_on_bus.red;
               req_green_sample <= meas_on_bus.green;
               req_blue_sample <= meas_on_bus.blue;
               req_hold <= meas_on_bus.hold;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : watch_colors
      color_result_t want;
      color_result_t got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.red_level = rsp_red_level;
            got.green_level = rsp_green_level;
            got.blue_level = rsp_blue_level;
            got.red_share = rsp_red_share;
            got.green_share = rsp_green_share;
            got.blue_share = rsp_blue_share;
            got.color_class = color_class_type'(rsp_color_class);
            colors_seen++;
            if (awaited_colors_q.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("ERROR: result beat with no measurement outstanding, class %0d",
                           rsp_color_class);
               end
            end else begin
               want = awaited_colors_q.pop_front();
               if (got !== want) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("ERROR: result %0d exp lvl %0d/%0d/%0d shr %0d/%0d/%0d cls %0d",
                              colors_seen, want.red_level, want.green_level,
                              want.blue_level, want.red_share, want.green_share,
                              want.blue_share, want.color_class);
                     $display("       got lvl %0d/%0d/%0d shr %0d/%0d/%0d cls %0d",
                              got.red_level, got.green_level, got.blue_level,
                              got.red_share, got.green_share, got.blue_share,
                              rsp_color_class);
                  end
               end else begin
                  class_hits[want.color_class]++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles", LIMIT_CYCLES);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // hold straight out of reset: stored levels still zero
      add_meas(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1);
      wait_idle();
      apply_setting(12'd0, 12'd0);
      add_meas(12'h000, 12'h000, 12'h000, 12'h000, 1'b1);
      add_meas(12'h000, 12'h000, 12'h000, 12'h000, 1'b0);
      wait_idle();

      apply_setting(12'd80, 12'd80);
      add_meas(12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
      add_meas(12'd0, 12'd4095, 12'd4095, 12'd4095, 1'b0);
      add_meas(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0);
      add_meas(12'd2000, 12'd1000, 12'd1999, 12'd2000, 1'b0);
      add_meas(12'd100, 12'd1100, 12'd900, 12'd800, 1'b0);
      add_meas(12'd0, 12'd3000, 12'd1000, 12'd1000, 1'b0);
      add_meas(12'd0, 12'd100, 12'd100, 12'd4000, 1'b0);
      add_meas(12'd0, 12'd0, 12'd800, 12'd1543, 1'b0);
      add_meas(12'd0, 12'd0, 12'd800, 12'd1545, 1'b0);
      add_meas(12'd0, 12'd79, 12'd63, 12'd113, 1'b0);
      add_meas(12'd0, 12'd80, 12'd63, 12'd113, 1'b0);
      add_meas(12'd0, 12'd1, 12'd1599, 12'd2, 1'b0);
      add_meas(12'h555, 12'hAAA, 12'h555, 12'hFFF, 1'b1);
      add_meas(12'h000, 12'hAAA, 12'h555, 12'hFFF, 1'b0);
      add_meas(12'h555, 12'hAAA, 12'hFFF, 12'h555, 1'b0);
      wait_idle();

      apply_setting(12'd4095, 12'd4095);
      add_meas(12'd0, 12'd4095, 12'd4095, 12'd4095, 1'b0);
      add_meas(12'd100, 12'd4095, 12'd3000, 12'd4095, 1'b0);
      wait_idle();

      run_random_phase(0, 0, DARK_THRESHOLD_RESET, GREEN_BLUE_MARGIN_RESET);
      run_random_phase(73, 0, 12'd4095, 12'd0);
      run_random_phase(0, 73, 12'd0, 12'd4095);
      run_random_phase(29, 29, CFG_BITS'($urandom), CFG_BITS'($urandom));
      run_random_phase(0, 0, CFG_BITS'($urandom_range(300)), CFG_BITS'($urandom_range(300)));

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_colors_q.size() != 0) begin
         fault_count += awaited_colors_q.size();
         $display("ERROR: %0d results never arrived", awaited_colors_q.size());
      end

      $display("Sent %0d measurements (%0d on hold) under %0d register settings, %0d results",
               meas_sent, hold_sent, setting_count, colors_seen);
      $display("Matching results by class none/green/red/blue: %0d/%0d/%0d/%0d",
               class_hits[CLASS_NONE], class_hits[CLASS_GREEN],
               class_hits[CLASS_RED], class_hits[CLASS_BLUE]);
      if (fault_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: rgb_reflectance_color_classifier_unit.f
sv/rrcc_pkg.sv
sv/rrcc_ctrl.sv
sv/rrcc_datapath.sv
sv/rgb_reflectance_color_classifier_unit.sv
tb/tb_rgb_reflectance_color_classifier_unit.sv
